// ===== hdl/index_argsort_macros.svh =====
// Assertion macros shared by the index_argsort checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef INDEX_ARGSORT_MACROS_SVH
`define INDEX_ARGSORT_MACROS_SVH

// Check sampled on the rising clock, off while reset is asserted
`define IA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check sampled on the rising clock, also during reset
`define IA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ia_pkg.sv =====
// Package for index_argsort: payload structs and controller/datapath link types.
// No dependencies.
package ia_pkg;

  // Output index field width, fixed by the result format
  localparam int unsigned POS_W = 6;

  typedef struct packed {
    logic signed [31:0] score;
    logic               last_in_set;
  } ia_in_t;

  typedef struct packed {
    logic [POS_W-1:0] sorted_index;
    logic             last_rank;
    logic             overflow;
  } ia_out_t;

  // Commands from controller to the cell chain
  typedef struct packed {
    logic insert;  // input transfer: place the score or drop it when full
    logic shift;   // output transfer: move the chain one rank toward cell 0
  } ia_cmd_t;

  // Status from the cell chain to the controller
  typedef struct packed {
    logic full;
    logic last_one;  // exactly one element left in the chain
  } ia_sts_t;

endpackage

// ===== hdl/ia_cells.sv =====
// Datapath of index_argsort: insertion-sorting chain of score/position cells.
// Depends on ia_pkg.
module ia_cells #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned SCORE_WIDTH  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ia_pkg::ia_cmd_t  cmd_i,
  input  ia_pkg::ia_in_t   in_data_i,
  output ia_pkg::ia_sts_t  sts_o,
  output ia_pkg::ia_out_t  out_data_o
);
  import ia_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic signed [SCORE_WIDTH-1:0] score_q [MAX_ELEMENTS];
  logic [POS_W-1:0]              pos_q   [MAX_ELEMENTS];
  logic [CW-1:0]                 count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic signed [SCORE_WIDTH-1:0] new_score;
  logic [POS_W-1:0]              new_pos;
  logic [MAX_ELEMENTS-1:0]       gt;
  logic                          full;

  // Sign-extend or wrap the incoming score to the store width
  assign new_score = SCORE_WIDTH'(in_data_i.score);
  assign new_pos   = POS_W'(count_q);
  assign full      = (count_q == CW'(MAX_ELEMENTS));

  // Per-cell compare: stored element ranks after the new score
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      gt[i] = (CW'(i) < count_q) && (score_q[i] > new_score);
    end
  end

  // Cells: insert opens a slot by moving larger elements up; shift drains to cell 0
  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    logic                          move;
    logic signed [SCORE_WIDTH-1:0] ins_score, nxt_score;
    logic [POS_W-1:0]              ins_pos, nxt_pos;

    assign move = gt[g] || (count_q == CW'(g));

    if (g == 0) begin : g_first
      assign ins_score = new_score;
      assign ins_pos   = new_pos;
    end else begin : g_rest
      assign ins_score = gt[g-1] ? score_q[g-1] : new_score;
      assign ins_pos   = gt[g-1] ? pos_q[g-1]   : new_pos;
    end

    if (g == MAX_ELEMENTS - 1) begin : g_top
      assign nxt_score = score_q[g];
      assign nxt_pos   = pos_q[g];
    end else begin : g_mid
      assign nxt_score = score_q[g+1];
      assign nxt_pos   = pos_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && !full && move) begin
        score_q[g] <= ins_score;
        pos_q[g]   <= ins_pos;
      end else if (cmd_i.shift) begin
        score_q[g] <= nxt_score;
        pos_q[g]   <= nxt_pos;
      end
    end
  end

  // Fill count and overflow flag
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.insert) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else if (cmd_i.shift) begin
      count_d = count_q - CW'(1);
      if (count_q == CW'(1)) begin
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign sts_o.full     = full;
  assign sts_o.last_one = (count_q == CW'(1));

  assign out_data_o.sorted_index = pos_q[0];
  assign out_data_o.last_rank    = (count_q == CW'(1));
  assign out_data_o.overflow     = ovf_q;

endmodule

// ===== hdl/ia_ctrl.sv =====
// Controller of index_argsort: load/emit state machine and handshakes.
// Depends on ia_pkg.
module ia_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  logic             out_stall_i,
  input  ia_pkg::ia_sts_t  sts_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output ia_pkg::ia_cmd_t  cmd_o
);
  import ia_pkg::*;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;
  logic in_xfer, out_xfer;

  assign in_stall_o  = (state_q == ST_EMIT);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;

  assign cmd_o.insert = in_xfer;
  assign cmd_o.shift  = out_xfer;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer && in_last_i) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && sts_i.last_one) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/index_argsort.sv =====
// Top level of index_argsort: ascending argsort of a set of Q16.16 scores.
// Depends on ia_pkg, ia_ctrl and ia_cells.
//
// Scores are taken one per cycle while in_stall_o is low and placed at once
// into a sorted chain of MAX_ELEMENTS cells, every cell comparing against the
// new score in parallel. The transfer marked last_in_set ends the set; from
// the next cycle the block emits the arrival positions in ascending score
// order, one result per cycle while out_stall_i is low, lowest position first
// among equal scores, with last_rank on the final one. Input is stalled while
// results drain. Scores beyond MAX_ELEMENTS are dropped and every result of
// that set carries overflow.
module index_argsort #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned SCORE_WIDTH  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ia_pkg::ia_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ia_pkg::ia_out_t out_data_o
);
  import ia_pkg::*;

  ia_cmd_t cmd;
  ia_sts_t sts;

  ia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_in_set),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ia_cells #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .SCORE_WIDTH  (SCORE_WIDTH)
  ) u_cells (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hdl/index_argsort_checker.sv =====
// Port-level assertions for index_argsort, bound to the top level.
// Depends on ia_pkg and index_argsort_macros.svh.
`include "index_argsort_macros.svh"

module index_argsort_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input ia_pkg::ia_in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input ia_pkg::ia_out_t out_data_o
);
  import ia_pkg::*;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // No input is taken while results are pending
  `IA_ASSERT_ALWAYS(a_no_load_while_emit, out_valid_o |-> in_stall_o, "input taken while emitting")

  // The last score of a set starts the result stream
  `IA_ASSERT(a_last_starts_emit, (in_xfer && in_data_i.last_in_set) |=> out_valid_o, "no results after last score")

  // Results keep coming until last_rank, then stop
  `IA_ASSERT(a_emit_continues, (out_xfer && !out_data_o.last_rank) |=> out_valid_o, "result stream broke off")
  `IA_ASSERT(a_emit_ends, (out_xfer && out_data_o.last_rank) |=> !out_valid_o, "result after last_rank")

endmodule

bind index_argsort index_argsort_checker u_chk (.*);
